FILE: hdl/wdce_pkg.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor package
// Shared types and constants for the RIFF/WAVE data chunk extractor.
// ----------------------------------------------------------------------------
package wdce_pkg;

   // Little-endian chunk tags as assembled from the byte stream
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // Parser phases
   typedef enum logic [3:0] {
      PH_RIFF  = 4'd0,
      PH_RSIZE = 4'd1,
      PH_WAVE  = 4'd2,
      PH_FMT   = 4'd3,
      PH_FSIZE = 4'd4,
      PH_FSKIP = 4'd5,
      PH_CTAG  = 4'd6,
      PH_CSIZE = 4'd7,
      PH_CSKIP = 4'd8,
      PH_DLEN  = 4'd9,
      PH_PAY   = 4'd10,
      PH_DONE  = 4'd11
   } phase_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_SHORT_END = 2'd1,
      KIND_HDR_ERR   = 2'd2,
      KIND_EMPTY     = 2'd3
   } kind_type;

   // One input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } item_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } result_type;

endpackage

FILE: hdl/wdce_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Input register with a skid entry, so that the ready towards the source is
// driven from a flip-flop.
// ----------------------------------------------------------------------------
module wdce_in_stage import wdce_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     item_valid,
   output item_type item,
   input  logic     item_take
);

   logic     main_vld_ff, main_vld_in;
   logic     skid_vld_ff, skid_vld_in;
   item_type main_ff, main_in;
   item_type skid_ff, skid_in;
   logic     accept;

   assign in_ready   = !skid_vld_ff;
   assign accept     = in_valid && in_ready;
   assign item_valid = main_vld_ff;
   assign item       = main_ff;

   // Refill the main entry from the skid entry first, then from the port.
   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (item_take || !main_vld_ff) begin
         if (skid_vld_ff) begin
            main_vld_in = 1'b1;
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            main_vld_in = accept;
            main_in     = in_item;
         end
      end else if (accept) begin
         skid_vld_in = 1'b1;
         skid_in     = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: hdl/wdce_parser.sv
// ----------------------------------------------------------------------------
// Header parser
// Tracks the RIFF/WAVE header, skips chunks by their size and passes the
// data chunk payload on. One byte is handled per cycle unless a result stalls.
// ----------------------------------------------------------------------------
module wdce_parser import wdce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   input  logic       out_free,
   output logic       res_push,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  wcnt_ff, wcnt_in;
   logic [31:0] shift_ff, shift_in;
   logic [30:0] left_ff, left_in;
   logic [31:0] word;
   logic [30:0] left_dec;
   logic        res_vld;

   assign word     = {item.data_byte, shift_ff[31:8]};
   assign left_dec = left_ff - 31'd1;

   // A transaction that yields a result waits for room in the result register.
   assign item_take = item_valid && (!res_vld || out_free);
   assign res_push  = item_take && res_vld;

   // Next state and result for the byte at the head of the input stage
   always_comb begin
      phase_in = phase_ff;
      wcnt_in  = wcnt_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      res_vld  = 1'b0;
      res      = '{out_byte: 8'd0, kind: KIND_HDR_ERR, last: 1'b1};
      if (item.end_of_input) begin
         // End of stream: report if nothing final was given, then rearm.
         if (phase_ff != PH_DONE) begin
            res_vld  = 1'b1;
            res.kind = (phase_ff == PH_PAY) ? KIND_SHORT_END : KIND_HDR_ERR;
         end
         phase_in = PH_RIFF;
         wcnt_in  = 2'd0;
         shift_in = 32'd0;
         left_in  = 31'd0;
      end else begin
         case (phase_ff)
            PH_PAY: begin
               left_in      = left_dec;
               res_vld      = 1'b1;
               res.out_byte = item.data_byte;
               res.kind     = KIND_PAYLOAD;
               res.last     = (left_dec == 31'd0);
               if (left_dec == 31'd0) begin
                  phase_in = PH_DONE;
               end
            end
            PH_FSKIP, PH_CSKIP: begin
               left_in = left_dec;
               if (left_dec == 31'd0) begin
                  phase_in = PH_CTAG;
               end
            end
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_CTAG, PH_CSIZE,
            PH_DLEN: begin
               // Assemble a little-endian word and act once it is complete.
               shift_in = word;
               wcnt_in  = wcnt_ff + 2'd1;
               if (wcnt_ff == 2'd3) begin
                  case (phase_ff)
                     PH_RIFF: begin
                        if (word != TAG_RIFF) begin
                           res_vld  = 1'b1;
                           phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_RSIZE;
                        end
                     end
                     PH_RSIZE: begin
                        phase_in = PH_WAVE;
                     end
                     PH_WAVE: begin
                        if (word != TAG_WAVE) begin
                           res_vld  = 1'b1;
                           phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_FMT;
                        end
                     end
                     PH_FMT: begin
                        if (word != TAG_FMT) begin
                           res_vld  = 1'b1;
                           phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_FSIZE;
                        end
                     end
                     PH_FSIZE, PH_CSIZE: begin
                        // A negative size is a header error, never a seek back.
                        if (word[31]) begin
                           res_vld  = 1'b1;
                           phase_in = PH_DONE;
                        end else begin
                           left_in = word[30:0];
                           if (word == 32'd0) begin
                              phase_in = PH_CTAG;
                           end else if (phase_ff == PH_FSIZE) begin
                              phase_in = PH_FSKIP;
                           end else begin
                              phase_in = PH_CSKIP;
                           end
                        end
                     end
                     PH_CTAG: begin
                        phase_in = (word == TAG_DATA) ? PH_DLEN : PH_CSIZE;
                     end
                     PH_DLEN: begin
                        if (word[31] || (word == 32'd0)) begin
                           res_vld  = 1'b1;
                           res.kind = KIND_EMPTY;
                           phase_in = PH_DONE;
                        end else begin
                           left_in  = word[30:0];
                           phase_in = PH_PAY;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
            default: begin
               // Done, or a code that means nothing: bytes are ignored.
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         wcnt_ff  <= 2'd0;
         shift_ff <= 32'd0;
         left_ff  <= 31'd0;
      end else if (item_take) begin
         phase_ff <= phase_in;
         wcnt_ff  <= wcnt_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
      end
   end

endmodule

FILE: hdl/wdce_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module wdce_out_stage import wdce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       res_push,
   input  result_type res,
   output logic       out_free,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic       vld_ff, vld_in;
   result_type res_ff, res_in;

   assign out_free  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_res   = res_ff;

   // Load on a push, empty when the sink takes the held result.
   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (res_push) begin
         vld_in = 1'b1;
         res_in = res;
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

endmodule

FILE: hdl/wav_data_chunk_extractor.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor
// Parses a RIFF/WAVE byte stream and passes on the payload of the data chunk.
//
//   Channel  Direction  tdata          tuser   tlast
//   req_     in         data_byte      -       end_of_input
//   rsp_     out        out_byte       kind    last
//
// One input transaction is taken every cycle when the result side keeps up.
// Each accepted request transaction is registered in the input stage, and its
// result, if any, is then registered in the result register for the sink.
// Bytes that give no result never wait for the sink.
// req_tready comes from the skid entry flip-flop, so a stall reaches the
// source in the next cycle and the skid entry absorbs the byte in flight.
// Reset is synchronous and returns the parser to expect the RIFF tag.
// ----------------------------------------------------------------------------
module wav_data_chunk_extractor import wdce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast    // last
);

   item_type   in_item;
   item_type   item;
   logic       item_valid;
   logic       item_take;
   logic       out_free;
   logic       res_push;
   result_type res;
   result_type out_res;

   assign in_item = '{data_byte: req_tdata, end_of_input: req_tlast};

   wdce_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   wdce_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_free   (out_free),
      .res_push   (res_push),
      .res        (res)
   );

   wdce_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res       (res),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = out_res.out_byte;
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

endmodule

FILE: hdl/wdce_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the extractor's ports for reset behaviour, status results and
// held results.
// ----------------------------------------------------------------------------
module wdce_checker import wdce_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // No result survives a reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The input side is open right after reset.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // A request on offer carries known data.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown({req_tdata, req_tlast}))
      else $error("request data unknown while valid");

   // Status results are always final and carry no byte.
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != KIND_PAYLOAD)) |-> (rsp_tlast && (rsp_tdata == 8'd0)))
      else $error("status result not final or carries a byte");

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind wav_data_chunk_extractor wdce_checker u_wdce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
